// ----- rtl/core/nsst_pkg.sv -----
// Shared sizes, codes and types for the note sustain / sostenuto tracker.
// Used by nsst_ctrl, nsst_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nsst_pkg;

	localparam int NOTE_COUNT = 128;
	localparam int SCAN_BANK  = 64;
	localparam int IDX_W      = $clog2(NOTE_COUNT);
	localparam int KIND_W     = 3;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int RANGE_W    = NOTE_W + 1;
	localparam int BANK_LAST  = ((1 << NOTE_W) - 1) / SCAN_BANK;

	localparam logic [KIND_W-1:0] K_NOTE    = 3'd0;
	localparam logic [KIND_W-1:0] K_SUS_ON  = 3'd1;
	localparam logic [KIND_W-1:0] K_SUS_OFF = 3'd2;
	localparam logic [KIND_W-1:0] K_SOST    = 3'd3;
	localparam logic [KIND_W-1:0] K_RELEASE = 3'd4;
	localparam logic [KIND_W-1:0] K_MUTE    = 3'd5;

	typedef enum logic [1:0] {
		NS_OFF  = 2'd0,
		NS_ON   = 2'd1,
		NS_HELD = 2'd2
	} nstate_t;

	typedef struct packed {
		logic    sus;
		nstate_t st;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{sus: 1'b0, st: NS_OFF};

	typedef enum logic [2:0] {
		CT_IDLE,
		CT_DECODE,
		CT_NOTE_EV,
		CT_NOTE_ON,
		CT_SCAN,
		CT_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic rd_note;
		logic rd_scan;
		logic wr_scan;
		logic wr_on;
		logic wr_held;
		logic wr_off;
		logic emit_off;
		logic emit_on;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic is_note;
		logic vel_zero;
		logic sounding;
		logic sus;
		logic scan_hit;
		logic scan_more;
		logic emit_ok;
	} dp_stat_t;

	// First note of the bank that holds n.
	function automatic logic [RANGE_W-1:0] bank_base(input logic [NOTE_W-1:0] n);
		logic [RANGE_W-1:0] b;
		b = '0;
		for (int k = 0; k <= BANK_LAST; k++) begin
			if ({1'b0, n} >= RANGE_W'(k * SCAN_BANK))
				b = RANGE_W'(k * SCAN_BANK);
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nsst_ctrl.sv -----
// Sequencing state machine for the note tracker.
// Drives dp_cmd_t to nsst_dp and reads dp_stat_t back; uses nsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsst_ctrl
	import nsst_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CT_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != CT_IDLE);
		case (state_q)
			CT_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = CT_DECODE;
				end
			end
			CT_DECODE: begin
				if (stat.is_note) begin
					cmd.rd_note = 1'b1;
					state_d     = CT_NOTE_EV;
				end else if (stat.scan_more) begin
					cmd.rd_scan = 1'b1;
					state_d     = CT_SCAN;
				end else begin
					state_d = CT_IDLE;
				end
			end
			CT_NOTE_EV: begin
				if (!stat.vel_zero) begin
					// retrigger: end the sounding note before the new note-on
					if (!stat.sounding) begin
						state_d = CT_NOTE_ON;
					end else if (stat.emit_ok) begin
						cmd.emit_off = 1'b1;
						state_d      = CT_NOTE_ON;
					end
				end else if (stat.sounding && stat.sus) begin
					cmd.wr_held = 1'b1;
					state_d     = CT_FLUSH;
				end else if (stat.sounding) begin
					if (stat.emit_ok) begin
						cmd.emit_off = 1'b1;
						cmd.wr_off   = 1'b1;
						state_d      = CT_FLUSH;
					end
				end else begin
					state_d = CT_FLUSH;
				end
			end
			CT_NOTE_ON: begin
				if (stat.emit_ok) begin
					cmd.wr_on   = 1'b1;
					cmd.emit_on = 1'b1;
					state_d     = CT_FLUSH;
				end
			end
			CT_SCAN: begin
				// hold the entry while a note-off has nowhere to go
				if (!stat.scan_hit || stat.emit_ok) begin
					cmd.wr_scan  = 1'b1;
					cmd.emit_off = stat.scan_hit;
					if (stat.scan_more)
						cmd.rd_scan = 1'b1;
					else
						state_d = CT_FLUSH;
				end
			end
			CT_FLUSH: begin
				if (stat.emit_ok) begin
					cmd.flush = 1'b1;
					state_d   = CT_IDLE;
				end
			end
			default: begin
				state_d = CT_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/nsst_dp.sv -----
// Datapath of the note tracker: item registers, note table, scan counter,
// pending message and output register. Commanded by nsst_ctrl; uses nsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsst_dp
	import nsst_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [NOTE_W-1:0] note,
	input  wire logic [VEL_W-1:0]  velocity,
	input  wire logic              all_notes,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [NOTE_W-1:0]      out_note,
	output logic [VEL_W-1:0]       out_velocity,
	output logic                   last
);

	// item registers
	logic [KIND_W-1:0]  kind_q;
	logic [NOTE_W-1:0]  note_q;
	logic [VEL_W-1:0]   vel_q;
	logic               is_note_q;
	logic               sost_pt_q;
	logic [RANGE_W-1:0] rd_idx_q;
	logic [RANGE_W-1:0] end_q;
	logic [IDX_W-1:0]   ev_idx_q;

	// note table
	entry_t                mem_q [NOTE_COUNT];
	logic [NOTE_COUNT-1:0] vld_q;
	entry_t                rdata_q;

	// message registers
	logic              pend_v_q;
	logic [NOTE_W-1:0] pend_note_q;
	logic [VEL_W-1:0]  pend_vel_q;
	logic              out_v_q;
	logic [NOTE_W-1:0] out_note_q;
	logic [VEL_W-1:0]  out_vel_q;
	logic              out_last_q;

	logic               note_ok;
	logic [RANGE_W-1:0] base;
	logic [RANGE_W-1:0] end_raw;
	logic [RANGE_W-1:0] bank_end;
	logic [RANGE_W-1:0] start_d;
	logic [RANGE_W-1:0] end_d;
	logic [RANGE_W-1:0] one_end;

	logic               sounding;
	logic               held;
	logic               scan_hit;
	entry_t             scan_new;
	entry_t             wdata;
	logic               wr_en;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               emit;
	logic               load_out;
	logic               out_free;
	logic               emit_ok;

	// scan range of the incoming item
	always_comb begin
		note_ok  = {1'b0, note} < RANGE_W'(NOTE_COUNT);
		base     = bank_base(note);
		end_raw  = base + RANGE_W'(SCAN_BANK);
		bank_end = (end_raw > RANGE_W'(NOTE_COUNT)) ? RANGE_W'(NOTE_COUNT) : end_raw;
		one_end  = RANGE_W'({1'b0, note}) + RANGE_W'(1);
		start_d  = '0;
		end_d    = '0;
		case (kind)
			K_SUS_ON, K_SUS_OFF: begin
				if (all_notes) begin
					end_d = RANGE_W'(NOTE_COUNT);
				end else if (note_ok) begin
					start_d = RANGE_W'({1'b0, note});
					end_d   = one_end;
				end
			end
			K_SOST: begin
				end_d = RANGE_W'(NOTE_COUNT);
			end
			K_RELEASE, K_MUTE: begin
				// a bank wholly past the table comes out empty
				if (all_notes) begin
					start_d = base;
					end_d   = bank_end;
				end else if (note_ok) begin
					start_d = RANGE_W'({1'b0, note});
					end_d   = one_end;
				end
			end
			default: begin
				end_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= kind;
			note_q    <= note;
			vel_q     <= velocity;
			is_note_q <= (kind == K_NOTE) && !all_notes && note_ok;
			sost_pt_q <= (kind == K_SOST) && !all_notes && note_ok;
			end_q     <= end_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			rd_idx_q <= start_d;
		else if (cmd.rd_scan)
			rd_idx_q <= rd_idx_q + RANGE_W'(1);
	end

	// per-entry update during a scan
	always_comb begin
		sounding = (rdata_q.st != NS_OFF);
		held     = (rdata_q.st == NS_HELD);
		scan_new = rdata_q;
		scan_hit = 1'b0;
		case (kind_q)
			K_SUS_ON: begin
				scan_new.sus = 1'b1;
			end
			K_SUS_OFF: begin
				scan_new.sus = 1'b0;
			end
			K_SOST: begin
				scan_new.sus = rdata_q.sus || sounding ||
					(sost_pt_q && (ev_idx_q == note_q[IDX_W-1:0]));
			end
			K_RELEASE: begin
				scan_hit     = held;
				scan_new.sus = 1'b0;
				if (held)
					scan_new.st = NS_OFF;
			end
			K_MUTE: begin
				scan_hit = sounding;
				if (sounding)
					scan_new.st = NS_OFF;
			end
			default: begin
				scan_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en = cmd.wr_scan || cmd.wr_on || cmd.wr_held || cmd.wr_off;
		wdata = scan_new;
		if (cmd.wr_on)
			wdata = '{sus: rdata_q.sus, st: NS_ON};
		else if (cmd.wr_held)
			wdata = '{sus: rdata_q.sus, st: NS_HELD};
		else if (cmd.wr_off)
			wdata = '{sus: rdata_q.sus, st: NS_OFF};
		rd_en   = cmd.rd_note || cmd.rd_scan;
		rd_addr = cmd.rd_scan ? rd_idx_q[IDX_W-1:0] : note_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[ev_idx_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (wr_en)
			vld_q[ev_idx_q] <= 1'b1;
	end

	// an entry never written reads as off with sustain clear
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= vld_q[rd_addr] ? mem_q[rd_addr] : ENTRY_RESET;
			ev_idx_q <= rd_addr;
		end
	end

	// one message waits in pend until the next one, or the flush, tells
	// whether it closes the item
	always_comb begin
		emit     = cmd.emit_off || cmd.emit_on;
		out_free = !out_v_q || !rsp_stall;
		emit_ok  = !pend_v_q || out_free;
		load_out = (emit || cmd.flush) && pend_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
			if (load_out)
				out_v_q <= 1'b1;
			else if (!rsp_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_note_q <= NOTE_W'(ev_idx_q);
			pend_vel_q  <= cmd.emit_on ? vel_q : '0;
		end
		if (load_out) begin
			out_note_q <= pend_note_q;
			out_vel_q  <= pend_vel_q;
			out_last_q <= cmd.flush;
		end
	end

	always_comb begin
		stat.is_note   = is_note_q;
		stat.vel_zero  = (vel_q == '0);
		stat.sounding  = sounding;
		stat.sus       = rdata_q.sus;
		stat.scan_hit  = scan_hit;
		stat.scan_more = (rd_idx_q < end_q);
		stat.emit_ok   = emit_ok;
	end

	assign rsp_valid    = out_v_q;
	assign out_note     = out_note_q;
	assign out_velocity = out_vel_q;
	assign last         = out_last_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_off || cmd.emit_on || cmd.flush) |-> emit_ok)
		else $error("message moved with no room in the output register");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && pend_v_q) |=> (rsp_valid && last))
		else $error("closing beat not presented with last");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_scan |-> (RANGE_W'(ev_idx_q) < end_q))
		else $error("scan wrote past the end of its range");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_scan |-> (rd_idx_q < end_q))
		else $error("scan read past the end of its range");

endmodule

`default_nettype wire

// ----- rtl/core/note_sustain_sostenuto_tracker_top.sv -----
// Note sustain / sostenuto tracker: state machine plus datapath.
// Instantiates nsst_ctrl and nsst_dp; uses nsst_pkg.
//
// Request channel (req_valid / req_stall): one beat carries kind, note,
// velocity and all_notes. The block takes one item at a time; req_stall is
// high from the beat until every resulting message is in the output register.
// Response channel (rsp_valid / rsp_stall): one note message per beat,
// out_velocity zero meaning note-off; last marks the final beat of an item.
// An item that causes no message gives no beat at all.
// A scan goes through the note table one entry a cycle through its single
// read port, except while a note-off waits for room: a release or mute of
// all notes covers the bank of SCAN_BANK notes that holds note, a
// sostenuto or sustain-all item all NOTE_COUNT entries.
// Reset (arst_n low) marks every note off with sustain clear at once
// through per-entry valid bits; no clearing pass is needed.
// When the receiver stalls, the output register holds its beat and one
// further message waits in a pending register; the scan then halts on the
// next hit until room appears.
`timescale 1ns / 1ps
`default_nettype none

module note_sustain_sostenuto_tracker_top
	import nsst_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [NOTE_W-1:0] note,
	input  wire logic [VEL_W-1:0]  velocity,
	input  wire logic              all_notes,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [NOTE_W-1:0]      out_note,
	output logic [VEL_W-1:0]       out_velocity,
	output logic                   last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	nsst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	nsst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.note         (note),
		.velocity     (velocity),
		.all_notes    (all_notes),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.out_note     (out_note),
		.out_velocity (out_velocity),
		.last         (last)
	);

endmodule

`default_nettype wire
